// ----- rtl/ghsm_pkg.sv -----
// Types and constants shared by the generational handle slot map.
`timescale 1ns / 1ps

package ghsm_pkg;

    localparam int SLOT_COUNT   = 256;
    localparam int INDEX_BITS   = 8;
    localparam int VERSION_BITS = 8;
    localparam int PAYLOAD_BITS = 32;
    localparam int TIME_BITS    = 32;
    localparam int HANDLE_BITS  = 16;
    localparam int COUNT_BITS   = INDEX_BITS + 1;
    localparam int LINK_BITS    = INDEX_BITS + 1;   // one extra bit for the empty marker

    // request modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    localparam logic [LINK_BITS-1:0]  FREE_EMPTY = LINK_BITS'(SLOT_COUNT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = COUNT_BITS'(SLOT_COUNT);

    // link: dense index while live, next free slot while free
    typedef struct packed {
        logic                    live;
        logic [VERSION_BITS-1:0] version;
        logic [LINK_BITS-1:0]    link;
    } slot_entry_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]   owner;
        logic [TIME_BITS-1:0]    stamp;
        logic [PAYLOAD_BITS-1:0] payload;
    } dense_entry_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MOVE = 6'b000100,
        S_FREE = 6'b001000,
        S_LOOK = 6'b010000,
        S_DONE = 6'b100000
    } ghsm_state_t;

endpackage

// ----- rtl/generational_handle_slot_map.sv -----
// Generational handle slot map: slot table, free list and dense swap-remove storage.
`timescale 1ns / 1ps

// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the mode (add, remove,
//   look up), s_tdata the handle, payload word and time stamp. Each request
//   gives exactly one result on the m_ stream: m_tuser carries the status,
//   m_tdata the handle, stored payload and time stamp and the live count.
//   Requests are handled one at a time. An add, a bad handle or an unknown
//   mode goes straight to the result; a lookup needs a second, dependent
//   read of the dense memory. Removing the last dense entry needs only the
//   write-back of the freed slot; any other remove reads the moved entry's
//   slot, then makes two write-backs through the single slot memory port.
//   The result is loaded into the output register as the engine returns
//   to idle.
//   A finished result waits in the output register while the next request
//   is taken; if the receiver still stalls when the next result is ready,
//   the engine holds that result and accepts nothing further.
//   Reset (aresetn low, synchronous) empties the map: no slots handed out,
//   free list empty, live count zero. The memories need no clearing.
module generational_handle_slot_map
    import ghsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // handle[15:0], payload[47:16], now_time[79:48]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // handle_out[15:0], payload_out[47:16], time_out[79:48],
                                   // live_count[88:80], zero above
    output logic [1:0]  m_tuser    // status[1:0]
);

    // memories
    slot_entry_t  slot_mem  [SLOT_COUNT];
    dense_entry_t dense_mem [SLOT_COUNT];

    logic [INDEX_BITS-1:0] slot_addr;
    logic                  slot_we;
    slot_entry_t           slot_wdata;
    slot_entry_t           slot_rdata_reg;
    logic [INDEX_BITS-1:0] dense_addr;
    logic                  dense_we;
    dense_entry_t          dense_wdata;
    dense_entry_t          dense_rdata_reg;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_addr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_addr];
    end

    always_ff @(posedge aclk) begin
        if (dense_we) begin
            dense_mem[dense_addr] <= dense_wdata;
        end
        dense_rdata_reg <= dense_mem[dense_addr];
    end

    // control state
    ghsm_state_t           state_reg, state_next;
    logic [LINK_BITS-1:0]  head_reg, head_next;
    logic [COUNT_BITS-1:0] slots_used_reg, slots_used_next;
    logic [COUNT_BITS-1:0] dense_count_reg, dense_count_next;
    logic                  out_valid_reg, out_valid_next;

    // request and work registers
    logic [1:0]              req_mode_reg;
    logic [HANDLE_BITS-1:0]  req_handle_reg;
    logic [PAYLOAD_BITS-1:0] req_payload_reg;
    logic [TIME_BITS-1:0]    req_time_reg;
    logic [INDEX_BITS-1:0]   mover_reg, mover_next;
    logic [INDEX_BITS-1:0]   hole_reg, hole_next;
    slot_entry_t             free_entry_reg, free_entry_next;

    logic [1:0]              res_status_reg, res_status_next;
    logic [HANDLE_BITS-1:0]  res_handle_reg, res_handle_next;
    logic [PAYLOAD_BITS-1:0] res_payload_reg, res_payload_next;
    logic [TIME_BITS-1:0]    res_time_reg, res_time_next;

    logic [1:0]              out_status_reg;
    logic [HANDLE_BITS-1:0]  out_handle_reg;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;
    logic [TIME_BITS-1:0]    out_time_reg;
    logic [COUNT_BITS-1:0]   out_count_reg;

    logic                    in_fire;
    logic                    out_load;
    logic [INDEX_BITS-1:0]   req_index;
    logic [VERSION_BITS-1:0] req_version;
    logic                    handle_ok;
    logic                    free_avail;
    logic                    add_ok;
    logic [INDEX_BITS-1:0]   add_slot;
    logic [VERSION_BITS-1:0] add_version;
    logic [INDEX_BITS-1:0]   last_dense;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    assign req_index   = req_handle_reg[INDEX_BITS-1:0];
    assign req_version = req_handle_reg[INDEX_BITS +: VERSION_BITS];
    assign last_dense  = dense_count_reg[INDEX_BITS-1:0] - INDEX_BITS'(1);

    // slot_rdata_reg holds the named slot's entry in the cycle after accept
    assign handle_ok = ({1'b0, req_index} < slots_used_reg) && slot_rdata_reg.live &&
                       (slot_rdata_reg.version == req_version) &&
                       (slot_rdata_reg.link < dense_count_reg);

    assign free_avail  = (head_reg < FREE_EMPTY);
    assign add_ok      = free_avail || (slots_used_reg < COUNT_MAX);
    assign add_slot    = free_avail ? head_reg[INDEX_BITS-1:0] : slots_used_reg[INDEX_BITS-1:0];
    assign add_version = free_avail ? slot_rdata_reg.version : '0;

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        slots_used_next  = slots_used_reg;
        dense_count_next = dense_count_reg;
        mover_next       = mover_reg;
        hole_next        = hole_reg;
        free_entry_next  = free_entry_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        res_payload_next = res_payload_reg;
        res_time_next    = res_time_reg;
        out_valid_next   = out_valid_reg;

        slot_addr   = req_index;
        slot_we     = 1'b0;
        slot_wdata  = '0;
        dense_addr  = last_dense;
        dense_we    = 1'b0;
        dense_wdata = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                // first reads: free-list head for add, named slot otherwise,
                // plus the last dense entry for a possible swap
                slot_addr  = (s_tuser == MODE_ADD) ? head_reg[INDEX_BITS-1:0]
                                                   : s_tdata[INDEX_BITS-1:0];
                dense_addr = last_dense;
                if (in_fire) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next  = STATUS_BAD;
                res_handle_next  = req_handle_reg;
                res_payload_next = '0;
                res_time_next    = '0;
                state_next       = S_DONE;
                case (req_mode_reg)
                    MODE_ADD: begin
                        if (!add_ok) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            if (free_avail) begin
                                head_next = slot_rdata_reg.link;
                            end else begin
                                slots_used_next = slots_used_reg + COUNT_BITS'(1);
                            end
                            if (dense_count_reg < COUNT_MAX) begin
                                dense_count_next    = dense_count_reg + COUNT_BITS'(1);
                                slot_addr           = add_slot;
                                slot_we             = 1'b1;
                                slot_wdata.live     = 1'b1;
                                slot_wdata.version  = add_version;
                                slot_wdata.link     = dense_count_reg;
                                dense_addr          = dense_count_reg[INDEX_BITS-1:0];
                                dense_we            = 1'b1;
                                dense_wdata.owner   = add_slot;
                                dense_wdata.stamp   = req_time_reg;
                                dense_wdata.payload = req_payload_reg;
                                res_status_next     = STATUS_OK;
                                res_handle_next     = HANDLE_BITS'({add_version, add_slot});
                            end else begin
                                res_status_next = STATUS_FULL;
                            end
                        end
                    end
                    MODE_REMOVE: begin
                        if (handle_ok) begin
                            res_status_next         = STATUS_OK;
                            dense_count_next        = dense_count_reg - COUNT_BITS'(1);
                            head_next               = {1'b0, req_index};
                            free_entry_next.live    = 1'b0;
                            free_entry_next.version = slot_rdata_reg.version + VERSION_BITS'(1);
                            free_entry_next.link    = head_reg;
                            hole_next               = slot_rdata_reg.link[INDEX_BITS-1:0];
                            mover_next              = dense_rdata_reg.owner;
                            if (slot_rdata_reg.link[INDEX_BITS-1:0] != last_dense) begin
                                // swap the last dense entry into the hole,
                                // fetch the mover's slot to relink it
                                dense_addr  = slot_rdata_reg.link[INDEX_BITS-1:0];
                                dense_we    = 1'b1;
                                dense_wdata = dense_rdata_reg;
                                slot_addr   = dense_rdata_reg.owner;
                                state_next  = S_MOVE;
                            end else begin
                                state_next = S_FREE;
                            end
                        end
                    end
                    MODE_LOOKUP: begin
                        if (handle_ok) begin
                            dense_addr = slot_rdata_reg.link[INDEX_BITS-1:0];
                            state_next = S_LOOK;
                        end
                    end
                    default: begin
                        res_status_next = STATUS_BAD;
                    end
                endcase
            end
            S_MOVE: begin
                slot_addr       = mover_reg;
                slot_we         = 1'b1;
                slot_wdata      = slot_rdata_reg;
                slot_wdata.link = {1'b0, hole_reg};
                state_next      = S_FREE;
            end
            S_FREE: begin
                slot_addr  = req_index;
                slot_we    = 1'b1;
                slot_wdata = free_entry_reg;
                state_next = S_DONE;
            end
            S_LOOK: begin
                res_status_next  = STATUS_OK;
                res_payload_next = dense_rdata_reg.payload;
                res_time_next    = dense_rdata_reg.stamp;
                state_next       = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            head_reg        <= FREE_EMPTY;
            slots_used_reg  <= '0;
            dense_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            slots_used_reg  <= slots_used_next;
            dense_count_reg <= dense_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_mode_reg    <= s_tuser;
            req_handle_reg  <= s_tdata[15:0];
            req_payload_reg <= s_tdata[47:16];
            req_time_reg    <= s_tdata[79:48];
        end
        mover_reg       <= mover_next;
        hole_reg        <= hole_next;
        free_entry_reg  <= free_entry_next;
        res_status_reg  <= res_status_next;
        res_handle_reg  <= res_handle_next;
        res_payload_reg <= res_payload_next;
        res_time_reg    <= res_time_next;
        if (out_load) begin
            out_status_reg  <= res_status_reg;
            out_handle_reg  <= res_handle_reg;
            out_payload_reg <= res_payload_reg;
            out_time_reg    <= res_time_reg;
            out_count_reg   <= dense_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_time_reg, out_payload_reg, out_handle_reg};

endmodule
